// File: design/mipsx_pkg.sv
// Shared widths, default sizes, operation and fault codes, and types of the MIPS subset executor.
package mipsx_pkg;

	// default sizes of the register file, the data memory and the program
	localparam int NUM_REGS_DEF   = 32;
	localparam int MEM_WORDS_DEF  = 32;
	localparam int PROG_DEPTH_DEF = 1024;

	// fixed field widths
	localparam int KIND_W    = 3;
	localparam int REG_IDX_W = 5;
	localparam int IMM_W     = 16;
	localparam int PC_W      = 10;
	localparam int WORD_W    = 32;
	localparam int FAULT_W   = 2;

	// operation codes
	localparam logic [KIND_W-1:0] KIND_LW  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SW  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ADD = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SUB = 3'd3;
	localparam logic [KIND_W-1:0] KIND_BEQ = 3'd4;

	// fault codes
	localparam logic [FAULT_W-1:0] FAULT_NONE   = 2'd0;
	localparam logic [FAULT_W-1:0] FAULT_MEM    = 2'd1;
	localparam logic [FAULT_W-1:0] FAULT_BRANCH = 2'd2;

	// clearing pass after reset, then normal operation
	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} exec_state_t;

endpackage

// File: design/mips_subset_instruction_executor.sv
// Top level of the MIPS subset executor (lw, sw, add, sub, beq) with register file and data memory.
//
//  channel | handshake            | payload                                          | dir
//  --------+----------------------+--------------------------------------------------+-----
//  input   | in_valid / in_ready  | kind, dest_reg, src_reg, second_reg, immediate,  | in
//          |                      | pc_now                                           |
//  result  | out_valid / out_ready| next_pc, branch_taken, value, fault              | out
//
//  Flow: one instruction beat per cycle while result beats are taken; each beat passes through
//  the register file read at acceptance, then execute, then the result stage, which offers it.
//  The rate is set by the register file read at acceptance and the data memory's one write
//  and one read port, which one instruction uses in its execute cycle.
//  Reset: a clearing pass over every register and memory address loads register 0 with zero and
//  every other register and memory word with one; in_ready stays low until it ends.
//  Stalls: a held result keeps the execute stage full; a held result behind a full execute
//  stage drops in_ready.
module mips_subset_instruction_executor #(
	parameter int NUM_REGS   = mipsx_pkg::NUM_REGS_DEF,
	parameter int MEM_WORDS  = mipsx_pkg::MEM_WORDS_DEF,
	parameter int PROG_DEPTH = mipsx_pkg::PROG_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,

	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [mipsx_pkg::KIND_W-1:0]          kind,
	input  logic [mipsx_pkg::REG_IDX_W-1:0]       dest_reg,
	input  logic [mipsx_pkg::REG_IDX_W-1:0]       src_reg,
	input  logic [mipsx_pkg::REG_IDX_W-1:0]       second_reg,
	input  logic signed [mipsx_pkg::IMM_W-1:0]    immediate,
	input  logic [mipsx_pkg::PC_W-1:0]            pc_now,

	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [mipsx_pkg::PC_W-1:0]            next_pc,
	output logic                                  branch_taken,
	output logic signed [mipsx_pkg::WORD_W-1:0]   value,
	output logic [mipsx_pkg::FAULT_W-1:0]         fault
);

	localparam int KW      = mipsx_pkg::KIND_W;
	localparam int IW      = mipsx_pkg::REG_IDX_W;
	localparam int IMW     = mipsx_pkg::IMM_W;
	localparam int PW      = mipsx_pkg::PC_W;
	localparam int WW      = mipsx_pkg::WORD_W;
	localparam int FW      = mipsx_pkg::FAULT_W;

	localparam int RW      = $clog2(NUM_REGS);
	localparam int MW      = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam int CLR_LEN = (NUM_REGS > MEM_WORDS) ? NUM_REGS : MEM_WORDS;
	localparam int CW      = $clog2(CLR_LEN);
	localparam int CNT_W   = CW + 1;
	localparam int LIM_W   = IW + 1;

	// sequential pc modulo PROG_DEPTH by reciprocal multiplication (exact for SEQ_W-bit values)
	localparam int SEQ_W   = PW + 1;
	localparam int RSH     = SEQ_W + $clog2(PROG_DEPTH);
	localparam int RECIP   = ((1 << RSH) + PROG_DEPTH - 1) / PROG_DEPTH;
	localparam int PROD_W  = RSH + SEQ_W + 2;

	localparam int TGT_W   = IMW + 2;
	localparam int EA_W    = WW + 1;

	// ------------------------------------------------------------------
	// clearing pass state machine
	// ------------------------------------------------------------------
	mipsx_pkg::exec_state_t state_q, state_d;
	logic [CW-1:0] clr_cnt_q;
	logic          clearing;
	logic          clr_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mipsx_pkg::ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_cnt_q <= clr_cnt_q + CW'(1);
			end
		end
	end

	always_comb begin
		clr_last = (clr_cnt_q == CW'(CLR_LEN - 1));
		clearing = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			mipsx_pkg::ST_CLEAR: begin
				clearing = 1'b1;
				if (clr_last) begin
					state_d = mipsx_pkg::ST_RUN;
				end
			end
			mipsx_pkg::ST_RUN: begin
				state_d = mipsx_pkg::ST_RUN;
			end
			default: begin
				state_d = mipsx_pkg::ST_CLEAR;
			end
		endcase
	end

	logic clr_reg_we;
	logic clr_mem_we;
	assign clr_reg_we = clearing && ({1'b0, clr_cnt_q} < CNT_W'(NUM_REGS));
	assign clr_mem_we = clearing && ({1'b0, clr_cnt_q} < CNT_W'(MEM_WORDS));

	// ------------------------------------------------------------------
	// handshake and pipeline occupancy
	// ------------------------------------------------------------------
	logic s1_valid_q;
	logic s2_valid_q;
	logic s2_free;
	logic in_acc;
	logic s1_mv;
	logic out_acc;

	assign s2_free  = !s2_valid_q || out_ready;
	assign in_ready = !clearing && (!s1_valid_q || s2_free);
	assign in_acc   = in_valid && in_ready;
	assign s1_mv    = s1_valid_q && s2_free;
	assign out_acc  = s2_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				s1_valid_q <= in_acc;
			end
			if (s2_free) begin
				s2_valid_q <= s1_valid_q;
			end
		end
	end

	// ------------------------------------------------------------------
	// input side: register file read addresses and pc quotient
	// ------------------------------------------------------------------
	logic [IW-1:0]     rda_in, rdb_in;
	logic [IW-1:0]     rda_idx, rdb_idx;
	logic [SEQ_W-1:0]  pc_inc_in;
	logic [PROD_W-1:0] quo_prod;

	// port a always reads src_reg; port b reads rt for add/sub, dest_reg otherwise
	assign rda_in = src_reg;
	assign rdb_in = (kind == mipsx_pkg::KIND_ADD || kind == mipsx_pkg::KIND_SUB) ?
	                second_reg : dest_reg;

	assign pc_inc_in = {1'b0, pc_now} + SEQ_W'(1);
	assign quo_prod  = PROD_W'(pc_inc_in) * PROD_W'(RECIP);

	// s1 payload
	logic [KW-1:0]         kind_s1;
	logic [IW-1:0]         dest_s1;
	logic [IW-1:0]         a_idx_s1;
	logic [IW-1:0]         b_idx_s1;
	logic signed [IMW-1:0] imm_s1;
	logic [PW-1:0]         pc_s1;
	logic [SEQ_W-1:0]      quo_s1;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1  <= kind;
			dest_s1  <= dest_reg;
			a_idx_s1 <= rda_in;
			b_idx_s1 <= rdb_in;
			imm_s1   <= immediate;
			pc_s1    <= pc_now;
			quo_s1   <= quo_prod[RSH +: SEQ_W];
		end
	end

	// reread the held item's registers every cycle while it waits, so that late writes land
	assign rda_idx = in_ready ? rda_in : a_idx_s1;
	assign rdb_idx = in_ready ? rdb_in : b_idx_s1;

	// ------------------------------------------------------------------
	// register file: two copies, one per read port, written together
	// ------------------------------------------------------------------
	logic          rf_wr;
	logic          rf_we;
	logic [RW-1:0] rf_waddr;
	logic [WW-1:0] rf_wdata;
	logic [WW-1:0] rfa_rdata, rfb_rdata;
	logic [WW-1:0] res_value;

	// s2 payload
	logic [PW-1:0] next_pc_s2;
	logic          taken_s2;
	logic [WW-1:0] value_s2;
	logic [FW-1:0] fault_s2;
	logic          load_s2;
	logic          reg_wr_s2;
	logic [IW-1:0] dest_s2;

	// retire the register write when the result beat is taken
	assign rf_wr    = out_acc && reg_wr_s2;
	assign rf_we    = clr_reg_we || rf_wr;
	assign rf_waddr = clearing ? clr_cnt_q[RW-1:0] : dest_s2[RW-1:0];
	assign rf_wdata = clearing ? ((clr_cnt_q == '0) ? '0 : WW'(1)) : res_value;

	mipsx_ram #(
		.WIDTH(WW),
		.DEPTH(NUM_REGS)
	) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.re    (1'b1),
		.raddr (rda_idx[RW-1:0]),
		.rdata (rfa_rdata)
	);

	mipsx_ram #(
		.WIDTH(WW),
		.DEPTH(NUM_REGS)
	) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.re    (1'b1),
		.raddr (rdb_idx[RW-1:0]),
		.rdata (rfb_rdata)
	);

	// catch a write that lands on the address read at the same edge
	logic          byp_a_q, byp_b_q;
	logic [WW-1:0] byp_data_q;

	always_ff @(posedge clk) begin
		byp_a_q    <= rf_wr && (dest_s2 == rda_idx);
		byp_b_q    <= rf_wr && (dest_s2 == rdb_idx);
		byp_data_q <= res_value;
	end

	// ------------------------------------------------------------------
	// s1: operand select and execute
	// ------------------------------------------------------------------
	logic          a_ok, b_ok, dest_ok;
	logic          fwd_a, fwd_b;
	logic [WW-1:0] opa, opb;

	assign a_ok    = ({1'b0, a_idx_s1} < LIM_W'(NUM_REGS));
	assign b_ok    = ({1'b0, b_idx_s1} < LIM_W'(NUM_REGS));
	assign dest_ok = ({1'b0, dest_s1} < LIM_W'(NUM_REGS)) && (dest_s1 != '0);

	// the older instruction still in s2 has not written yet: forward its result
	assign fwd_a = s2_valid_q && reg_wr_s2 && (dest_s2 == a_idx_s1);
	assign fwd_b = s2_valid_q && reg_wr_s2 && (dest_s2 == b_idx_s1);

	always_comb begin
		priority if (!a_ok) begin
			opa = '0;
		end else if (fwd_a) begin
			opa = res_value;
		end else if (byp_a_q) begin
			opa = byp_data_q;
		end else begin
			opa = rfa_rdata;
		end
		priority if (!b_ok) begin
			opb = '0;
		end else if (fwd_b) begin
			opb = res_value;
		end else if (byp_b_q) begin
			opb = byp_data_q;
		end else begin
			opb = rfb_rdata;
		end
	end

	logic is_lw, is_sw, is_mem, is_alu, is_beq;
	assign is_lw  = (kind_s1 == mipsx_pkg::KIND_LW);
	assign is_sw  = (kind_s1 == mipsx_pkg::KIND_SW);
	assign is_mem = is_lw || is_sw;
	assign is_alu = (kind_s1 == mipsx_pkg::KIND_ADD) || (kind_s1 == mipsx_pkg::KIND_SUB);
	assign is_beq = (kind_s1 == mipsx_pkg::KIND_BEQ);

	// effective byte address: exact signed sum, word index drops the two low bits
	logic [EA_W-1:0] ea;
	logic            mem_fault;
	assign ea        = {opa[WW-1], opa} + {{(EA_W - IMW){imm_s1[IMW-1]}}, imm_s1};
	assign mem_fault = is_mem &&
	                   (ea[EA_W-1] || (ea[EA_W-1:2] >= (EA_W - 2)'(MEM_WORDS)));

	logic [WW-1:0] alu;
	assign alu = (kind_s1 == mipsx_pkg::KIND_ADD) ? (opa + opb) : (opa - opb);

	// branch target and its range
	logic [TGT_W-1:0] tgt;
	logic             br_hit, br_oor, br_take;
	assign tgt     = {{(TGT_W - PW){1'b0}}, pc_s1} + TGT_W'(1) +
	                 {{(TGT_W - IMW){imm_s1[IMW-1]}}, imm_s1};
	assign br_hit  = is_beq && (opa == opb);
	assign br_oor  = tgt[TGT_W-1] || (tgt >= TGT_W'(PROG_DEPTH));
	assign br_take = br_hit && !br_oor;

	// sequential pc: (pc + 1) - quotient * PROG_DEPTH
	logic [SEQ_W-1:0] seq_pc;
	assign seq_pc = ({1'b0, pc_s1} + SEQ_W'(1)) - (quo_s1 * SEQ_W'(PROG_DEPTH));

	logic [FW-1:0] fault_d;
	logic [WW-1:0] value_d;
	logic          load_d;
	always_comb begin
		priority if (mem_fault) begin
			fault_d = mipsx_pkg::FAULT_MEM;
		end else if (br_hit && br_oor) begin
			fault_d = mipsx_pkg::FAULT_BRANCH;
		end else begin
			fault_d = mipsx_pkg::FAULT_NONE;
		end
		priority if (mem_fault) begin
			value_d = '0;
		end else if (is_sw) begin
			value_d = opb;
		end else if (is_alu) begin
			value_d = alu;
		end else begin
			value_d = '0;
		end
		load_d = is_lw && !mem_fault;
	end

	// ------------------------------------------------------------------
	// data memory: store writes and load reads as the item enters s2
	// ------------------------------------------------------------------
	logic          dm_we, dm_re;
	logic [MW-1:0] dm_waddr;
	logic [WW-1:0] dm_wdata;
	logic [WW-1:0] dm_rdata;

	assign dm_we    = clr_mem_we || (s1_mv && is_sw && !mem_fault);
	assign dm_re    = s1_mv && load_d;
	assign dm_waddr = clearing ? clr_cnt_q[MW-1:0] : ea[MW+1:2];
	assign dm_wdata = clearing ? WW'(1) : opb;

	mipsx_ram #(
		.WIDTH(WW),
		.DEPTH(MEM_WORDS)
	) u_dmem (
		.clk   (clk),
		.we    (dm_we),
		.waddr (dm_waddr),
		.wdata (dm_wdata),
		.re    (dm_re),
		.raddr (ea[MW+1:2]),
		.rdata (dm_rdata)
	);

	// ------------------------------------------------------------------
	// s2: result stage
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (s1_mv) begin
			next_pc_s2 <= br_take ? tgt[PW-1:0] : seq_pc[PW-1:0];
			taken_s2   <= br_take;
			value_s2   <= value_d;
			fault_s2   <= fault_d;
			load_s2    <= load_d;
			reg_wr_s2  <= (load_d || is_alu) && dest_ok;
			dest_s2    <= dest_s1;
		end
	end

	// a load takes its word from the memory's read register, held while the beat waits
	assign res_value = load_s2 ? dm_rdata : value_s2;

	assign out_valid    = s2_valid_q;
	assign next_pc      = next_pc_s2;
	assign branch_taken = taken_s2;
	assign value        = res_value;
	assign fault        = fault_s2;

`ifndef SYNTHESIS
	a_no_reg0_write: assert property (@(posedge clk) disable iff (!arst_n)
		rf_wr |-> (dest_s2 != '0) && ({1'b0, dest_s2} < LIM_W'(NUM_REGS)))
		else $error("register write to register zero or beyond the file");

	a_fault_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (fault != mipsx_pkg::FAULT_NONE) |-> (value == '0) && !branch_taken)
		else $error("faulted beat carries a value or a taken branch");

	a_load_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q && load_s2 && !out_ready |=> $stable(dm_rdata))
		else $error("load data changed while its beat was stalled");

	a_run_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mipsx_pkg::ST_RUN) |=> (state_q == mipsx_pkg::ST_RUN) && !clr_mem_we)
		else $error("clearing pass restarted after reset");
`endif

endmodule

// File: design/mipsx_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module mipsx_ram #(
	parameter int WIDTH = mipsx_pkg::WORD_W,
	parameter int DEPTH = mipsx_pkg::NUM_REGS_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old word when the same address is written in the same cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
